// ===== design/door_motion_controller_macros.svh =====
// assertion macros for the door motion controller
// used by door_motion_controller.sv; compiled out when SYNTHESIS is defined
`ifndef DOOR_MOTION_CONTROLLER_MACROS_SVH
`define DOOR_MOTION_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clock, off during reset
`define DMC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("door controller check failed in current cycle");

// next-cycle implication, sampled on clock, off during reset
`define DMC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("door controller check failed in next cycle");

`else

`define DMC_ASSERT_NOW(label, ante, cons)
`define DMC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== design/dmc_pkg.sv =====
// shared types, constants and codes of the door motion controller
// used by every module of the block; depends on nothing
package dmc_pkg;

   localparam int unsigned FRAC_BITS  = 16;
   localparam int unsigned REQ_BITS   = 8;
   localparam int unsigned POS_W      = FRAC_BITS + 1;
   localparam int unsigned FULL       = 1 << FRAC_BITS;
   localparam int unsigned MS_W       = 10;
   localparam int unsigned TIMER_W    = 20;
   localparam int unsigned FUNC_W     = 3;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 20;

   localparam int unsigned TRAVEL_RATE_RESET = 66;
   localparam int unsigned AUTOCLOSE_RESET   = 3000;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_OPEN   = 3'd0,
      FUNC_CLOSE  = 3'd1,
      FUNC_TOGGLE = 3'd2,
      FUNC_LOCK   = 3'd3,
      FUNC_UNLOCK = 3'd4,
      FUNC_USE    = 3'd5,
      FUNC_TICK   = 3'd6,
      FUNC_RELOAD = 3'd7
   } func_type;

   typedef enum logic [2:0] {
      EV_STATUS      = 3'd0,
      EV_REFUSED     = 3'd1,
      EV_OPEN_START  = 3'd2,
      EV_CLOSE_START = 3'd3,
      EV_OPENED      = 3'd4,
      EV_CLOSED      = 3'd5
   } event_type;

   typedef enum logic [1:0] {
      MOTION_IDLE    = 2'd0,
      MOTION_OPENING = 2'd1,
      MOTION_CLOSING = 2'd2
   } motion_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_TRAVEL_RATE      = 3'd0,
      CSR_AUTOCLOSE_MS     = 3'd1,
      CSR_AUTOCLOSE_ENABLE = 3'd2,
      CSR_NO_USE           = 3'd3,
      CSR_FORCE_CLOSE      = 3'd4,
      CSR_START_LOCKED     = 3'd5,
      CSR_START_OPENED     = 3'd6
   } csr_index_type;

   typedef struct packed {
      func_type            func;
      logic [REQ_BITS-1:0] requester_id;
      logic [MS_W-1:0]     elapsed_ms;
      logic                obstructed;
   } req_type;

   typedef struct packed {
      event_type           event_res;
      logic [REQ_BITS-1:0] event_requester;
      logic [POS_W-1:0]    eased_position;
      logic [POS_W-1:0]    linear_position;
      logic                target_is_open;
      motion_type          motion;
      logic                is_locked;
      logic                last_result;
   } rsp_type;

   typedef struct packed {
      logic [POS_W-1:0]   travel_rate;
      logic [TIMER_W-1:0] autoclose_ms;
      logic               autoclose_enable;
      logic               no_use;
      logic               force_close;
      logic               start_locked;
      logic               start_opened;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic action;
      logic travel;
      logic ease_sq;
      logic ease_mul;
      logic emit;
      logic last_res;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic ev_hit;
      logic out_free;
   } status_type;

endpackage

// ===== design/dmc_ctrl.sv =====
// sequencing state machine of the door motion controller
// depends on dmc_pkg; drives the datapath through dmc_pkg::cmd_type
module dmc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  dmc_pkg::status_type status,
   output dmc_pkg::cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_STEP     = 7'b0000010,
      ST_ACTION   = 7'b0000100,
      ST_TRAVEL   = 7'b0001000,
      ST_EASE_SQ  = 7'b0010000,
      ST_EASE_MUL = 7'b0100000,
      ST_EMIT     = 7'b1000000
   } state_type;

   // which result is being built
   typedef enum logic [1:0] {
      KIND_ACTION = 2'd0,
      KIND_TRAVEL = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            state_in = ST_ACTION;
         end
         ST_ACTION: begin
            cmd.action = 1'b1;
            if (status.ev_hit) begin
               kind_in  = KIND_ACTION;
               state_in = ST_EASE_SQ;
            end else begin
               state_in = ST_TRAVEL;
            end
         end
         ST_TRAVEL: begin
            cmd.travel = 1'b1;
            kind_in    = status.ev_hit ? KIND_TRAVEL : KIND_STATUS;
            state_in   = ST_EASE_SQ;
         end
         ST_EASE_SQ: begin
            cmd.ease_sq = 1'b1;
            state_in    = ST_EASE_MUL;
         end
         ST_EASE_MUL: begin
            cmd.ease_mul = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.last_res = (kind_ff == KIND_STATUS);
            if (status.out_free) begin
               cmd.emit = 1'b1;
               unique case (kind_ff)
                  KIND_ACTION: begin
                     state_in = ST_TRAVEL;
                  end
                  KIND_TRAVEL: begin
                     kind_in  = KIND_STATUS;
                     state_in = ST_EASE_SQ;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= KIND_STATUS;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

// ===== design/dmc_datapath.sv =====
// door state, shared multiplier, easing and result register
// depends on dmc_pkg; steered by dmc_ctrl through dmc_pkg::cmd_type
module dmc_datapath (
   input  logic                clock,
   input  logic                reset,
   input  dmc_pkg::cfg_type    cfg,
   input  dmc_pkg::req_type    req_data,
   input  dmc_pkg::cmd_type    cmd,
   output dmc_pkg::status_type status,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output dmc_pkg::rsp_type    rsp_data
);

   localparam int unsigned F      = dmc_pkg::FRAC_BITS;
   localparam int unsigned POS_W  = dmc_pkg::POS_W;
   localparam int unsigned MUL_W  = F + 2;
   localparam int unsigned PROD_W = 2 * MUL_W;
   localparam int unsigned STEP_W = dmc_pkg::MS_W + POS_W;
   localparam int unsigned SUM_W  = STEP_W + 1;
   localparam int unsigned EASE_W = PROD_W - F;
   localparam int unsigned TMR_W  = dmc_pkg::TIMER_W;
   localparam int unsigned RQ_W   = dmc_pkg::REQ_BITS;
   localparam logic [MUL_W-1:0] COEF3 = MUL_W'(3) << F;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_OPEN  = 2'd1,
      OP_CLOSE = 2'd2
   } op_type;

   // door state
   logic               target_ff, target_in;
   logic               mo_ff, mo_in;
   logic               mc_ff, mc_in;
   logic               lock_ff, lock_in;
   logic [POS_W-1:0]   frac_ff, frac_in;
   logic               armed_ff, armed_in;
   logic [TMR_W-1:0]   elapsed_ff, elapsed_in;
   logic [RQ_W-1:0]    last_ff, last_in;

   // per-item working registers
   dmc_pkg::req_type   item_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [MUL_W-1:0]   sq_ff;
   logic [POS_W-1:0]   ease_ff;
   logic               travel_en_ff, travel_en_in;
   dmc_pkg::event_type ev_code_ff, ev_code_in;
   logic [RQ_W-1:0]    ev_req_ff, ev_req_in;
   logic               ev_hit;

   logic               rsp_valid_ff, rsp_valid_in;
   dmc_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   op_type             op;
   logic [RQ_W-1:0]    op_req;
   logic [TMR_W:0]     timer_sum;
   logic [SUM_W-1:0]   open_sum;

   logic [MUL_W-1:0]   mul_a, mul_b;
   logic [PROD_W-1:0]  mul_prod;
   logic [MUL_W-1:0]   coef;
   logic [EASE_W-1:0]  ease_raw;

   // shared multiplier: travel step, t*t, then sq*(3-2t)
   assign coef = COEF3 - {frac_ff, 1'b0};

   always_comb begin
      if (cmd.step) begin
         mul_a = MUL_W'(item_ff.elapsed_ms);
         mul_b = MUL_W'(cfg.travel_rate);
      end else if (cmd.ease_sq) begin
         mul_a = MUL_W'(frac_ff);
         mul_b = MUL_W'(frac_ff);
      end else begin
         mul_a = sq_ff;
         mul_b = coef;
      end
   end

   assign mul_prod = {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};
   assign ease_raw = mul_prod[PROD_W-1:F];

   // action and travel phases, written in the order the door reacts
   always_comb begin
      target_in    = target_ff;
      mo_in        = mo_ff;
      mc_in        = mc_ff;
      lock_in      = lock_ff;
      frac_in      = frac_ff;
      armed_in     = armed_ff;
      elapsed_in   = elapsed_ff;
      last_in      = last_ff;
      travel_en_in = travel_en_ff;
      ev_code_in   = ev_code_ff;
      ev_req_in    = ev_req_ff;
      ev_hit       = 1'b0;
      op           = OP_NONE;
      op_req       = item_ff.requester_id;
      timer_sum    = '0;
      open_sum     = '0;

      if (cmd.action) begin
         travel_en_in = 1'b0;
         unique case (item_ff.func)
            dmc_pkg::FUNC_OPEN: begin
               op = OP_OPEN;
            end
            dmc_pkg::FUNC_CLOSE: begin
               op = OP_CLOSE;
            end
            dmc_pkg::FUNC_TOGGLE: begin
               op = target_ff ? OP_CLOSE : OP_OPEN;
            end
            dmc_pkg::FUNC_LOCK: begin
               lock_in = 1'b1;
            end
            dmc_pkg::FUNC_UNLOCK: begin
               lock_in = 1'b0;
            end
            dmc_pkg::FUNC_USE: begin
               if (!cfg.no_use) begin
                  op = (cfg.autoclose_enable || !target_ff) ? OP_OPEN : OP_CLOSE;
               end
            end
            dmc_pkg::FUNC_TICK: begin
               if (mo_ff || mc_ff) begin
                  travel_en_in = 1'b1;
                  if (item_ff.obstructed && !cfg.force_close) begin
                     op     = target_ff ? OP_CLOSE : OP_OPEN;
                     op_req = last_ff;
                  end
               end else if (armed_ff) begin
                  timer_sum  = {1'b0, elapsed_ff} + (TMR_W + 1)'(item_ff.elapsed_ms);
                  elapsed_in = timer_sum[TMR_W] ? {TMR_W{1'b1}} : timer_sum[TMR_W-1:0];
                  if (elapsed_in >= cfg.autoclose_ms) begin
                     armed_in   = 1'b0;
                     elapsed_in = '0;
                     op         = OP_CLOSE;
                     op_req     = last_ff;
                  end
               end
            end
            dmc_pkg::FUNC_RELOAD: begin
               lock_in    = cfg.start_locked;
               target_in  = cfg.start_opened;
               frac_in    = cfg.start_opened ? POS_W'(dmc_pkg::FULL) : '0;
               mo_in      = 1'b0;
               mc_in      = 1'b0;
               armed_in   = 1'b0;
               elapsed_in = '0;
            end
         endcase

         case (op)
            OP_OPEN: begin
               if (lock_in) begin
                  ev_hit     = 1'b1;
                  ev_code_in = dmc_pkg::EV_REFUSED;
                  ev_req_in  = op_req;
               end else if (!target_in) begin
                  target_in  = 1'b1;
                  mc_in      = 1'b0;
                  mo_in      = 1'b1;
                  last_in    = op_req;
                  ev_hit     = 1'b1;
                  ev_code_in = dmc_pkg::EV_OPEN_START;
                  ev_req_in  = op_req;
               end
            end
            OP_CLOSE: begin
               if (lock_in) begin
                  ev_hit     = 1'b1;
                  ev_code_in = dmc_pkg::EV_REFUSED;
                  ev_req_in  = op_req;
               end else if (target_in) begin
                  target_in  = 1'b0;
                  mo_in      = 1'b0;
                  armed_in   = 1'b0;
                  elapsed_in = '0;
                  mc_in      = 1'b1;
                  last_in    = op_req;
                  ev_hit     = 1'b1;
                  ev_code_in = dmc_pkg::EV_CLOSE_START;
                  ev_req_in  = op_req;
               end
            end
            default: ;
         endcase
      end

      if (cmd.travel && travel_en_ff) begin
         if (mo_ff) begin
            open_sum = {1'b0, step_ff} + SUM_W'(frac_ff);
            if (open_sum >= SUM_W'(dmc_pkg::FULL)) begin
               frac_in = POS_W'(dmc_pkg::FULL);
               mo_in   = 1'b0;
               mc_in   = 1'b0;
               if (cfg.autoclose_enable) begin
                  armed_in   = 1'b1;
                  elapsed_in = '0;
               end
               ev_hit     = 1'b1;
               ev_code_in = dmc_pkg::EV_OPENED;
               ev_req_in  = last_ff;
            end else begin
               frac_in = open_sum[POS_W-1:0];
            end
         end else if (mc_ff) begin
            // a closing door at zero completes even with a zero step
            if (step_ff >= STEP_W'(frac_ff)) begin
               frac_in    = '0;
               mo_in      = 1'b0;
               mc_in      = 1'b0;
               ev_hit     = 1'b1;
               ev_code_in = dmc_pkg::EV_CLOSED;
               ev_req_in  = last_ff;
            end else begin
               frac_in = frac_ff - step_ff[POS_W-1:0];
            end
         end
      end
   end

   // result beat, snapshot of the state after the last change
   always_comb begin
      rsp_data_in                 = rsp_data_ff;
      rsp_data_in.event_res       = cmd.last_res ? dmc_pkg::EV_STATUS : ev_code_ff;
      rsp_data_in.event_requester = cmd.last_res ? last_ff : ev_req_ff;
      rsp_data_in.eased_position  = ease_ff;
      rsp_data_in.linear_position = frac_ff;
      rsp_data_in.target_is_open  = target_ff;
      rsp_data_in.motion          = mo_ff ? dmc_pkg::MOTION_OPENING :
                                    (mc_ff ? dmc_pkg::MOTION_CLOSING : dmc_pkg::MOTION_IDLE);
      rsp_data_in.is_locked       = lock_ff;
      rsp_data_in.last_result     = cmd.last_res;
   end

   assign rsp_valid_in    = cmd.emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign status.ev_hit   = ev_hit;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= 1'b0;
         mo_ff        <= 1'b0;
         mc_ff        <= 1'b0;
         lock_ff      <= 1'b0;
         frac_ff      <= '0;
         armed_ff     <= 1'b0;
         elapsed_ff   <= '0;
         last_ff      <= '0;
         travel_en_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         target_ff    <= target_in;
         mo_ff        <= mo_in;
         mc_ff        <= mc_in;
         lock_ff      <= lock_in;
         frac_ff      <= frac_in;
         armed_ff     <= armed_in;
         elapsed_ff   <= elapsed_in;
         last_ff      <= last_in;
         travel_en_ff <= travel_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_code_ff <= ev_code_in;
      ev_req_ff  <= ev_req_in;
      if (cmd.load) begin
         item_ff <= req_data;
      end
      if (cmd.step) begin
         step_ff <= mul_prod[STEP_W-1:0];
      end
      if (cmd.ease_sq) begin
         sq_ff <= mul_prod[F+MUL_W-1:F];
      end
      if (cmd.ease_mul) begin
         ease_ff <= (ease_raw > EASE_W'(dmc_pkg::FULL)) ?
                    POS_W'(dmc_pkg::FULL) : ease_raw[POS_W-1:0];
      end
      if (cmd.emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== design/door_motion_controller.sv =====
// Door motion controller. Takes door commands (open, close, toggle, lock, unlock, use,
// reload) and millisecond ticks on the req_ channel, one item at a time, and answers each
// item with up to two event beats (refused, open/close started, opened, closed) followed
// by one status beat with last_result set, all carrying the raw Q1.16 travel fraction and
// its smoothstep. One 18x18 multiplier forms the travel step and then the two easing
// products of every beat, and a beat waits while the rsp_ side stalls. req_stall is low
// only while the sequencer is idle, so items are taken one at a time; a finished beat may
// still wait in the output register while the next item is taken. Registers are written
// through csr_ at any time the block is idle, csr_ready is always high, and index 7 is
// ignored.
`include "door_motion_controller_macros.svh"

module door_motion_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dmc_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dmc_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dmc_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [dmc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   dmc_pkg::cfg_type    cfg_ff, cfg_in;
   dmc_pkg::cmd_type    cmd;
   dmc_pkg::status_type status;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_addr)
            dmc_pkg::CSR_TRAVEL_RATE:      cfg_in.travel_rate = csr_wdata[dmc_pkg::POS_W-1:0];
            dmc_pkg::CSR_AUTOCLOSE_MS:     cfg_in.autoclose_ms = csr_wdata[dmc_pkg::TIMER_W-1:0];
            dmc_pkg::CSR_AUTOCLOSE_ENABLE: cfg_in.autoclose_enable = csr_wdata[0];
            dmc_pkg::CSR_NO_USE:           cfg_in.no_use = csr_wdata[0];
            dmc_pkg::CSR_FORCE_CLOSE:      cfg_in.force_close = csr_wdata[0];
            dmc_pkg::CSR_START_LOCKED:     cfg_in.start_locked = csr_wdata[0];
            dmc_pkg::CSR_START_OPENED:     cfg_in.start_opened = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.travel_rate      <= dmc_pkg::POS_W'(dmc_pkg::TRAVEL_RATE_RESET);
         cfg_ff.autoclose_ms     <= dmc_pkg::TIMER_W'(dmc_pkg::AUTOCLOSE_RESET);
         cfg_ff.autoclose_enable <= 1'b0;
         cfg_ff.no_use           <= 1'b0;
         cfg_ff.force_close      <= 1'b0;
         cfg_ff.start_locked     <= 1'b0;
         cfg_ff.start_opened     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dmc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // positions never pass fully open
   `DMC_ASSERT_NOW(a_pos_range, rsp_valid, (rsp_data.linear_position <= dmc_pkg::POS_W'(dmc_pkg::FULL)) && (rsp_data.eased_position <= dmc_pkg::POS_W'(dmc_pkg::FULL)))
   // an opening door is always commanded open
   `DMC_ASSERT_NOW(a_open_target, rsp_valid && (rsp_data.motion == dmc_pkg::MOTION_OPENING), rsp_data.target_is_open)
   // only one datapath step at a time
   `DMC_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0({cmd.load, cmd.step, cmd.action, cmd.travel, cmd.ease_sq, cmd.ease_mul, cmd.emit}))
   // a taken item keeps the input side busy
   `DMC_ASSERT_NEXT(a_busy_after_take, req_valid && !req_stall, req_stall)

endmodule
